FILE: sv/ilp_pkg.sv
// Shared constants, codes and types for the immediate literal parser.
`default_nettype none
package ilp_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int OUT_W               = 32;
    localparam int EXT_W               = 64;
    localparam int CH_W                = 8;
    localparam int DIGIT_W             = 5;

    localparam logic [2:0] PH_START       = 3'd0;
    localparam logic [2:0] PH_SIGN        = 3'd1;
    localparam logic [2:0] PH_ZERO        = 3'd2;
    localparam logic [2:0] PH_ZERO_SIGNED = 3'd3;
    localparam logic [2:0] PH_DIGITS      = 3'd4;

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_BIN = 2'd1;
    localparam logic [1:0] RX_OCT = 2'd2;
    localparam logic [1:0] RX_HEX = 2'd3;

    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CH_W-1:0] CH_LO_D  = 8'h64;
    localparam logic [CH_W-1:0] CH_LO_O  = 8'h6F;
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CASE_BIT = 8'h20;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd16;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] radix;
        logic       negative;
        logic       bad;
        logic       ovf;
    } t_ctl;

    typedef struct packed {
        logic status;
        logic overflow;
    } t_res;

    localparam t_ctl CTL_RESET = '{phase: PH_START, radix: RX_DEC,
                                   negative: 1'b0, bad: 1'b0, ovf: 1'b0};

    function automatic logic [DIGIT_W-1:0] base_of(input logic [1:0] rx);
        logic [DIGIT_W-1:0] b;
        unique case (rx)
            RX_BIN:  b = 5'd2;
            RX_OCT:  b = 5'd8;
            RX_HEX:  b = 5'd16;
            default: b = 5'd10;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: sv/ilp_step.sv
// Next-state and result logic for one character of a literal token.
`default_nettype none
module ilp_step import ilp_pkg::*; #(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  t_ctl                   i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_acc,
    input  logic [CH_W-1:0]        i_ch,
    output t_ctl                   o_ctl,
    output logic [VALUE_WIDTH-1:0] o_acc,
    output t_res                   o_res,
    output logic [OUT_W-1:0]       o_value
);

    localparam int PW = VALUE_WIDTH + 4;

    logic [DIGIT_W-1:0]     dig;
    logic                   dig_ok;
    logic [PW-1:0]          acc_x;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          sum;
    logic                   is_letter;
    logic [CH_W-1:0]        lc;
    logic                   lone_sign;
    logic                   prefix_only;
    logic                   take;
    logic                   invalid;
    logic [VALUE_WIDTH-1:0] mag;
    logic signed [VALUE_WIDTH-1:0] sval;
    logic signed [EXT_W-1:0]       ext;

    always_comb begin
        priority if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            dig = DIGIT_W'(i_ch - CH_ZERO);
        end else if (i_ch >= CH_LO_A && i_ch <= CH_LO_F) begin
            dig = DIGIT_W'(i_ch - CH_LO_A + 8'd10);
        end else if (i_ch >= CH_UP_A && i_ch <= CH_UP_F) begin
            dig = DIGIT_W'(i_ch - CH_UP_A + 8'd10);
        end else begin
            dig = NO_DIGIT;
        end
        dig_ok = dig < base_of(i_ctl.radix);
    end

    assign acc_x = PW'(i_acc);

    always_comb begin
        unique case (i_ctl.radix)
            RX_BIN:  prod = acc_x << 1;
            RX_OCT:  prod = acc_x << 3;
            RX_HEX:  prod = acc_x << 4;
            default: prod = (acc_x << 3) + (acc_x << 1);
        endcase
        sum = prod + PW'(dig);
    end

    assign is_letter = (i_ch >= CH_LO_A && i_ch <= CH_LO_Z) ||
                       (i_ch >= CH_UP_A && i_ch <= CH_UP_Z);
    assign lc        = i_ch | CASE_BIT;

    always_comb begin
        o_ctl       = i_ctl;
        o_acc       = i_acc;
        lone_sign   = 1'b0;
        prefix_only = 1'b0;
        take        = 1'b0;
        if (!i_ctl.bad) begin
            unique case (i_ctl.phase)
                PH_START: begin
                    if (i_ch == CH_MINUS || i_ch == CH_PLUS) begin
                        o_ctl.negative = (i_ch == CH_MINUS);
                        o_ctl.phase    = PH_SIGN;
                        lone_sign      = 1'b1;
                    end else if (i_ch == CH_ZERO) begin
                        o_ctl.phase = PH_ZERO;
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (i_ch == CH_ZERO) begin
                        o_ctl.phase = PH_ZERO_SIGNED;
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_ZERO, PH_ZERO_SIGNED: begin
                    if (is_letter) begin
                        prefix_only = 1'b1;
                        o_ctl.phase = PH_DIGITS;
                        priority if (lc == CH_LO_D) begin
                            o_ctl.radix = RX_DEC;
                        end else if (i_ctl.phase == PH_ZERO_SIGNED) begin
                            o_ctl.bad = 1'b1;
                        end else if (lc == CH_LO_B) begin
                            o_ctl.radix = RX_BIN;
                        end else if (lc == CH_LO_O) begin
                            o_ctl.radix = RX_OCT;
                        end else if (lc == CH_LO_X) begin
                            o_ctl.radix = RX_HEX;
                        end else begin
                            o_ctl.bad = 1'b1;
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase
            if (take) begin
                if (!dig_ok) begin
                    o_ctl.bad = 1'b1;
                end else begin
                    o_ctl.ovf   = i_ctl.ovf | (|sum[PW-1:VALUE_WIDTH]);
                    o_acc       = sum[VALUE_WIDTH-1:0];
                    o_ctl.phase = PH_DIGITS;
                end
            end
        end
    end

    assign invalid = o_ctl.bad | lone_sign | prefix_only;
    assign mag     = o_ctl.negative ? (~o_acc + VALUE_WIDTH'(1)) : o_acc;
    assign sval    = signed'(mag);
    assign ext     = EXT_W'(sval);

    assign o_res.status   = invalid;
    assign o_res.overflow = !invalid && o_ctl.ovf;
    assign o_value        = invalid ? '0 : ext[OUT_W-1:0];

endmodule
`default_nettype wire

FILE: sv/immediate_literal_parser_unit.sv
// Top level of the immediate literal parser: token state and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | i_ch, i_last_char
//  result  | out       | o_valid / i_stall  | o_status, o_value, o_overflow
//
// One character per cycle while o_stall is low; the token state updates in the cycle it is taken.
// A result is registered and appears in the cycle after its last character is taken.
// Reset (synchronous, i_rst_n low) returns the token state to start of token.
// Input stalls only while a result waits and the output side stalls.
`default_nettype none
module immediate_literal_parser_unit import ilp_pkg::*; #(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CH_W-1:0]  i_ch,
    input  logic             i_last_char,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_status,
    output logic [OUT_W-1:0] o_value,
    output logic             o_overflow
);

    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] n_acc;
    t_res                   n_res;
    logic [OUT_W-1:0]       n_value;
    logic                   r_vld;
    t_res                   r_res;
    logic [OUT_W-1:0]       r_value;
    logic                   xfer;

    ilp_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .i_ctl  (r_ctl),
        .i_acc  (r_acc),
        .i_ch   (i_ch),
        .o_ctl  (n_ctl),
        .o_acc  (n_acc),
        .o_res  (n_res),
        .o_value(n_value)
    );

    assign o_stall = r_vld & i_stall;
    assign xfer    = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CTL_RESET;
            r_acc <= '0;
        end else if (xfer) begin
            if (i_last_char) begin
                r_ctl <= CTL_RESET;
                r_acc <= '0;
            end else begin
                r_ctl <= n_ctl;
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (xfer && i_last_char) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer && i_last_char) begin
            r_res   <= n_res;
            r_value <= n_value;
        end
    end

    assign o_valid    = r_vld;
    assign o_status   = r_res.status;
    assign o_value    = r_value;
    assign o_overflow = r_res.overflow;

endmodule
`default_nettype wire

FILE: sv/ilp_checker.sv
// Port-level assertions for the immediate literal parser and their bind.
`default_nettype none
module ilp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_ch,
    input logic        i_last_char,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_status,
    input logic [31:0] o_value,
    input logic        o_overflow
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("stalled result changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_value == 32'd0 && !o_overflow)
        else $error("invalid token carries value or overflow");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_last_char))
        else $error("result without a last character transfer");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last_char && !(o_valid && i_stall) |=> !o_valid)
        else $error("result from a middle character");

endmodule

bind immediate_literal_parser_unit ilp_checker u_ilp_checker (.*);
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the immediate literal parser: stimulus, prediction, checks.
module tb_top;
    import ilp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_CHARS  = 900;
    localparam int PAUSE_AT_CHAR = 480;
    localparam int LONG_HOLD_AT  = 40;
    localparam int LONG_HOLD_LEN = 400;
    localparam int MAX_WAIT      = 12;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic            last;
        int              gap;
        bit              sync;
    } t_char_item;

    typedef struct packed {
        logic             status;
        logic [OUT_W-1:0] value;
        logic             overflow;
    } t_lit_result;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [CH_W-1:0]  i_ch        = '0;
    logic             i_last_char = 1'b0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_status;
    logic [OUT_W-1:0] o_value;
    logic             o_overflow;

    t_char_item       pending[$];
    logic [CH_W-1:0]  tok[$];
    t_lit_result      expected_results[$];

    string limit_lits [0:11] = '{"4294967295", "4294967296", "2147483647", "-2147483648",
                                 "0xffffffff", "0X100000000", "0o37777777777", "0o40000000000",
                                 "0b11111111111111111111111111111111", "99999999999",
                                 "+0", "-0d0"};

    int  errors         = 0;
    int  cycles         = 0;
    int  results_seen   = 0;
    int  queued_chars   = 0;
    int  gap_left       = 0;
    bit  gap_loaded     = 1'b0;
    int  stall_left     = 0;
    bit  rx_calm        = 1'b0;
    bit  tx_calm        = 1'b0;
    bit  hold_next      = 1'b0;
    bit  long_hold_done = 1'b0;
    bit  in_xfer        = 1'b0;
    bit  out_xfer       = 1'b0;

    logic [2:0]       lit_phase = PH_START;
    logic [1:0]       lit_radix = RX_DEC;
    logic             lit_neg   = 1'b0;
    logic [OUT_W-1:0] lit_accum = '0;
    logic             lit_bad   = 1'b0;
    logic             lit_ovf   = 1'b0;

    immediate_literal_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ch        (i_ch),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_overflow  (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    task automatic add_digit(input logic [CH_W-1:0] c);
        logic [4:0]  d;
        logic [4:0]  base;
        logic [63:0] next;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d = 5'(c - CH_LO_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = 5'(c - CH_UP_A + 8'd10);
        end
        case (lit_radix)
            RX_BIN: base = 5'd2;
            RX_OCT: base = 5'd8;
            RX_HEX: base = 5'd16;
            default: base = 5'd10;
        endcase
        if (d >= base) begin
            lit_bad = 1'b1;
        end else begin
            next = 64'(lit_accum) * 64'(base) + 64'(d);
            if (next > 64'hFFFF_FFFF) lit_ovf = 1'b1;
            lit_accum = next[OUT_W-1:0];
            lit_phase = PH_DIGITS;
        end
    endtask

    task automatic parse_char(input logic [CH_W-1:0] c, input logic last);
        logic        prefix_only;
        logic        lone_sign;
        logic        invalid;
        t_lit_result r;
        prefix_only = 1'b0;
        lone_sign   = 1'b0;
        if (!lit_bad) begin
            case (lit_phase)
                PH_START: begin
                    if (c == CH_MINUS || c == CH_PLUS) begin
                        lit_neg   = (c == CH_MINUS);
                        lit_phase = PH_SIGN;
                        lone_sign = 1'b1;
                    end else if (c == CH_ZERO) begin
                        lit_phase = PH_ZERO;
                    end else begin
                        add_digit(c);
                    end
                end
                PH_SIGN: begin
                    if (c == CH_ZERO) lit_phase = PH_ZERO_SIGNED;
                    else add_digit(c);
                end
                PH_ZERO, PH_ZERO_SIGNED: begin
                    if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
                        if ((c | CASE_BIT) == CH_LO_D) lit_radix = RX_DEC;
                        else if (lit_phase == PH_ZERO_SIGNED) lit_bad = 1'b1;
                        else if ((c | CASE_BIT) == CH_LO_B) lit_radix = RX_BIN;
                        else if ((c | CASE_BIT) == CH_LO_O) lit_radix = RX_OCT;
                        else if ((c | CASE_BIT) == CH_LO_X) lit_radix = RX_HEX;
                        else lit_bad = 1'b1;
                        lit_phase   = PH_DIGITS;
                        prefix_only = 1'b1;
                    end else begin
                        add_digit(c);
                    end
                end
                default: add_digit(c);
            endcase
        end
        if (last) begin
            invalid    = lit_bad || lone_sign || prefix_only;
            r.status   = invalid;
            r.value    = invalid ? '0 : (lit_neg ? -lit_accum : lit_accum);
            r.overflow = !invalid && lit_ovf;
            expected_results.push_back(r);
            lit_phase = PH_START;
            lit_radix = RX_DEC;
            lit_neg   = 1'b0;
            lit_accum = '0;
            lit_bad   = 1'b0;
            lit_ovf   = 1'b0;
        end
    endtask

    task automatic load_text(input string s);
        tok.delete();
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    endtask

    task automatic add_digits(input int base, input int n);
        int v;
        repeat (n) begin
            v = $urandom_range(0, base - 1);
            if (v < 10) tok.push_back(CH_ZERO + 8'(v));
            else tok.push_back(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 10));
        end
    endtask

    function automatic logic [CH_W-1:0] any_case(input logic [CH_W-1:0] c);
        return c ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
    endfunction

    task automatic build_literal();
        int n;
        tok.delete();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        case ($urandom_range(0, 3))
            0: begin
                tok.push_back(CH_ZERO);
                case ($urandom_range(0, 3))
                    0: begin tok.push_back(any_case(CH_LO_B)); add_digits(2, n); end
                    1: begin tok.push_back(any_case(CH_LO_O)); add_digits(8, n); end
                    2: begin tok.push_back(any_case(CH_LO_D)); add_digits(10, n); end
                    default: begin tok.push_back(any_case(CH_LO_X)); add_digits(16, n); end
                endcase
            end
            1: begin
                tok.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                if ($urandom_range(0, 1)) begin
                    tok.push_back(CH_ZERO);
                    tok.push_back(any_case(CH_LO_D));
                end
                add_digits(10, n);
            end
            2: add_digits(10, n);
            default: load_text(limit_lits[$urandom_range(0, 11)]);
        endcase
    endtask

    task automatic emit_token();
        t_char_item it;
        for (int i = 0; i < tok.size(); i++) begin
            it.ch   = tok[i];
            it.last = (i == tok.size() - 1);
            it.gap  = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            it.sync = hold_next && (i == 0);
            pending.push_back(it);
        end
        hold_next    = 1'b0;
        queued_chars += tok.size();
    endtask

    // driver
    always @(negedge i_clk) begin
        t_char_item cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_xfer) begin
            if (!gap_loaded && pending.size() != 0) begin
                gap_left   = pending[0].gap;
                gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (gap_loaded && !(pending[0].sync && expected_results.size() != 0)) begin
                cur = pending.pop_front();
                gap_loaded = 1'b0;
                i_ch        <= cur.ch;
                i_last_char <= cur.last;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (out_xfer) begin
            if (results_seen == LONG_HOLD_AT && !long_hold_done) begin
                stall_left     = LONG_HOLD_LEN;
                long_hold_done = 1'b1;
            end else begin
                if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
        end
        i_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_lit_result want;
        in_xfer  <= i_rst_n && i_valid && !o_stall;
        out_xfer <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected transfer: status %0b value %0d overflow %0b",
                           o_status, $signed(o_value), o_overflow);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0b, got %0b", want.status, o_status);
                        errors++;
                    end
                    if (o_value !== want.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(want.value), $signed(o_value));
                        errors++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow, o_overflow);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall) parse_char(i_ch, i_last_char);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int kind;
        int k;
        int goal;
        bit pause_done;
        pause_done = 1'b0;

        load_text("+");      emit_token();
        load_text("-");      emit_token();
        load_text("0");      emit_token();
        load_text("-0");     emit_token();
        load_text("05");     emit_token();
        load_text("0q");     emit_token();
        load_text("-0x1");   emit_token();
        load_text("0b");     emit_token();
        load_text("0o8");    emit_token();
        load_text("0D9");    emit_token();
        tok.delete();
        tok.push_back(8'hFF); emit_token();
        load_text("1");
        tok.push_front(8'h00); emit_token();

        hold_next = 1'b1;
        goal = queued_chars + RANDOM_CHARS;
        while (queued_chars < goal) begin
            if (!pause_done && queued_chars >= PAUSE_AT_CHAR) begin
                hold_next  = 1'b1;
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 11) == 0) tx_calm = !tx_calm;
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_literal();
            end else if (kind < 85) begin
                build_literal();
                case ($urandom_range(0, 2))
                    0: begin
                        k = $urandom_range(0, tok.size() - 1);
                        case ($urandom_range(0, 2))
                            0: tok[k] = 8'($urandom_range(0, 255));
                            1: tok[k] = any_case(CH_LO_A + 8'($urandom_range(0, 25)));
                            default: tok[k] = CH_ZERO + 8'($urandom_range(0, 9));
                        endcase
                    end
                    1: begin
                        k = $urandom_range(1, 2);
                        while (tok.size() > k) tok.delete(tok.size() - 1);
                    end
                    default: begin
                        tok.delete();
                        tok.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                        tok.push_back(CH_ZERO);
                        tok.push_back(any_case(CH_LO_A + 8'($urandom_range(0, 25))));
                        add_digits(10, $urandom_range(0, 3));
                    end
                endcase
            end else begin
                tok.delete();
                repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
            end
            emit_token();
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
